// ===== sv/pssd_pkg.sv =====
// Package for the patch SSD distance unit: request/response payload types,
// field widths, register codes and reset values. No dependencies.
`default_nettype none

package pssd_pkg;

   localparam int SUM_W     = 28;
   localparam int COORD_W   = 12;
   localparam int COLOR_W   = 8;
   localparam int OFFS_W    = 6;
   localparam int DIM_REG_W = 13;
   localparam int EDGE_W    = 6;
   localparam int COST_W    = 2 * COLOR_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam int DEFAULT_MAX_PATCH = 32;
   localparam int DEFAULT_MAX_DIM   = 4096;
   localparam int MIN_EDGE          = 2;

   localparam logic [SUM_W-1:0]     SUM_MASK     = {SUM_W{1'b1}};
   localparam logic [DIM_REG_W-1:0] RESET_WIDTH  = DIM_REG_W'(640);
   localparam logic [DIM_REG_W-1:0] RESET_HEIGHT = DIM_REG_W'(480);
   localparam logic [EDGE_W-1:0]    RESET_EDGE   = EDGE_W'(7);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PATCH_EDGE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] tgt_x;
      logic [COORD_W-1:0] tgt_y;
   } centre_type;

   typedef struct packed {
      logic [SUM_W-1:0]   reject_threshold;
      logic [COORD_W-1:0] src_center_x;
      logic [COORD_W-1:0] src_center_y;
      logic [COORD_W-1:0] tgt_center_x;
      logic [COORD_W-1:0] tgt_center_y;
      logic [COLOR_W-1:0] src_red;
      logic [COLOR_W-1:0] src_green;
      logic [COLOR_W-1:0] src_blue;
      logic [COLOR_W-1:0] tgt_red;
      logic [COLOR_W-1:0] tgt_green;
      logic [COLOR_W-1:0] tgt_blue;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] distance_sum;
      logic             rejected;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/pssd_pixel_cost.sv =====
// Squared RGB difference of one source/target pixel pair.
// Depends on pssd_pkg for the pixel type and widths.
`default_nettype none

module pssd_pixel_cost
   import pssd_pkg::*;
(
   input  pixel_type         src,
   input  pixel_type         tgt,
   output logic [COST_W-1:0] cost
);

   function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      logic signed [2*COLOR_W:0] d;
      d = $signed({{(COLOR_W+1){1'b0}}, a}) - $signed({{(COLOR_W+1){1'b0}}, b});
      return (2*COLOR_W)'(d * d);
   endfunction

   assign cost = COST_W'(sq_diff(src.red, tgt.red))
               + COST_W'(sq_diff(src.green, tgt.green))
               + COST_W'(sq_diff(src.blue, tgt.blue));

endmodule

`default_nettype wire

// ===== sv/pssd_bounds.sv =====
// Image bounds check of the four patch coordinates at one patch offset.
// Depends on pssd_pkg for the centre type and widths.
`default_nettype none

module pssd_bounds
   import pssd_pkg::*;
(
   input  centre_type           centres,
   input  logic [OFFS_W-1:0]    col,
   input  logic [OFFS_W-1:0]    row,
   input  logic [OFFS_W-1:0]    half,
   input  logic [DIM_REG_W-1:0] width,
   input  logic [DIM_REG_W-1:0] height,
   output logic                 outside
);

   localparam int POS_W = COORD_W + 3;

   function automatic logic off_image(input logic [COORD_W-1:0]   c,
                                      input logic [OFFS_W-1:0]    o,
                                      input logic [OFFS_W-1:0]    hf,
                                      input logic [DIM_REG_W-1:0] lim);
      logic signed [POS_W-1:0] pos;
      pos = $signed({{(POS_W-COORD_W){1'b0}}, c})
          + $signed({{(POS_W-OFFS_W){1'b0}}, o})
          - $signed({{(POS_W-OFFS_W){1'b0}}, hf});
      return (pos < 0) || (pos >= $signed({{(POS_W-DIM_REG_W){1'b0}}, lim}));
   endfunction

   assign outside = off_image(centres.src_x, col, half, width)
                 || off_image(centres.src_y, row, half, height)
                 || off_image(centres.tgt_x, col, half, width)
                 || off_image(centres.tgt_y, row, half, height);

endmodule

`default_nettype wire

// ===== sv/patch_ssd_distance_unit.sv =====
// Patch SSD distance unit, top level: input register, accumulate/compare
// stage, result register. Depends on pssd_pkg, pssd_pixel_cost, pssd_bounds.
`default_nettype none

// Usage
//    Configure image_width, image_height and patch_edge over the csr_ port
//    while the unit is idle. Then stream one patch comparison as
//    2*(p/2) x 2*(p/2) pixel-pair requests in row order on req_. The first
//    request of a patch supplies threshold and centres; later ones only pixels.
//    After the last request of a patch one response appears on rsp_: the
//    sum of squared differences, or all ones with rejected set when a
//    coordinate left the image or the running sum passed the threshold.
// Throughput and pipeline
//    One request per cycle, sustained while no held response stalls the stage.
//    A request is registered at acceptance and is accumulated when the stage
//    advances; at a patch's last request the response then goes to the result
//    register. The rate is set by the accumulate and threshold compare loop.
// Reset and stall
//    Synchronous reset clears the pipeline valids and the patch state, so the
//    next request starts a patch, and restores the register defaults. When
//    rsp_ready is low the response is held; requests keep flowing until a
//    second patch end meets the held response, then req_ready drops.
module patch_ssd_distance_unit
   import pssd_pkg::*;
#(
   parameter int MAX_PATCH = DEFAULT_MAX_PATCH,
   parameter int MAX_DIM   = DEFAULT_MAX_DIM
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rsp_type              rsp_data,
   input  wire                  csr_wr_en,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [DIM_REG_W-1:0]  csr_wr_data
);

   // configuration registers
   logic [DIM_REG_W-1:0] width_ff, width_in;
   logic [DIM_REG_W-1:0] height_ff, height_in;
   logic [EDGE_W-1:0]    edge_ff, edge_in;

   // input register
   logic    stage_valid_ff, stage_valid_in;
   req_type stage_data_ff, stage_data_in;

   // patch state
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [OFFS_W-1:0] col_ff, col_in;
   logic [OFFS_W-1:0] row_ff, row_in;
   logic              rej_ff, rej_in;
   logic [SUM_W-1:0]  thr_ff, thr_in;
   centre_type        centres_ff, centres_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic [EDGE_W-1:0]    p_low, p_eff;
   logic [OFFS_W-1:0]    half, last;
   logic [DIM_REG_W-1:0] w_eff, h_eff;
   logic                 first, patch_end, fire, outside;
   logic [SUM_W-1:0]     thr_use, acc_base, sat_sum, acc_next;
   logic                 rej_base, rej_next;
   centre_type           centres_use;
   logic [COST_W-1:0]    cost;
   logic [SUM_W:0]       sum_wide;
   pixel_type            src_px, tgt_px;

   // config writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      edge_in   = edge_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_wr_data;
            CSR_PATCH_EDGE:   edge_in   = csr_wr_data[EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp patch size and image dimensions
   always_comb begin
      p_low = (edge_ff < EDGE_W'(MIN_EDGE)) ? EDGE_W'(MIN_EDGE) : edge_ff;
      p_eff = (int'(p_low) > MAX_PATCH) ? EDGE_W'(MAX_PATCH) : p_low;
      half  = OFFS_W'(p_eff >> 1);
      last  = OFFS_W'(half << 1) - OFFS_W'(1);
      w_eff = (int'(width_ff) > MAX_DIM) ? DIM_REG_W'(MAX_DIM) : width_ff;
      h_eff = (int'(height_ff) > MAX_DIM) ? DIM_REG_W'(MAX_DIM) : height_ff;
   end

   // the first request of a patch brings its own threshold and centres
   always_comb begin
      first       = (col_ff == '0) && (row_ff == '0);
      thr_use     = first ? stage_data_ff.reject_threshold : thr_ff;
      centres_use = first ? centre_type'{src_x: stage_data_ff.src_center_x,
                                         src_y: stage_data_ff.src_center_y,
                                         tgt_x: stage_data_ff.tgt_center_x,
                                         tgt_y: stage_data_ff.tgt_center_y}
                          : centres_ff;
      acc_base    = first ? '0 : acc_ff;
      rej_base    = first ? 1'b0 : rej_ff;
      src_px      = pixel_type'{red: stage_data_ff.src_red,
                                green: stage_data_ff.src_green,
                                blue: stage_data_ff.src_blue};
      tgt_px      = pixel_type'{red: stage_data_ff.tgt_red,
                                green: stage_data_ff.tgt_green,
                                blue: stage_data_ff.tgt_blue};
   end

   pssd_pixel_cost u_cost (
      .src  (src_px),
      .tgt  (tgt_px),
      .cost (cost)
   );

   pssd_bounds u_bounds (
      .centres (centres_use),
      .col     (col_ff),
      .row     (row_ff),
      .half    (half),
      .width   (w_eff),
      .height  (h_eff),
      .outside (outside)
   );

   // accumulate with saturation, then threshold compare
   always_comb begin
      sum_wide = {1'b0, acc_base} + (SUM_W+1)'(cost);
      sat_sum  = sum_wide[SUM_W] ? SUM_MASK : sum_wide[SUM_W-1:0];
      if (rej_base || outside) begin
         acc_next = acc_base;
         rej_next = 1'b1;
      end else begin
         acc_next = sat_sum;
         rej_next = sat_sum > thr_use;
      end
   end

   // advance the stage unless a patch end meets a held response
   assign patch_end = (col_ff >= last) && (row_ff >= last);
   assign fire      = stage_valid_ff && (!patch_end || !out_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || fire;

   always_comb begin
      stage_valid_in = req_ready ? req_valid : stage_valid_ff;
      stage_data_in  = (req_valid && req_ready) ? req_data : stage_data_ff;

      acc_in     = acc_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rej_in     = rej_ff;
      thr_in     = thr_ff;
      centres_in = centres_ff;
      if (fire) begin
         acc_in     = acc_next;
         rej_in     = rej_next;
         thr_in     = thr_use;
         centres_in = centres_use;
         if (patch_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff >= last) begin
            col_in = '0;
            row_in = row_ff + OFFS_W'(1);
         end else begin
            col_in = col_ff + OFFS_W'(1);
         end
      end

      out_data_in = out_data_ff;
      if (fire && patch_end) begin
         out_valid_in             = 1'b1;
         out_data_in.distance_sum = rej_next ? SUM_MASK : acc_next;
         out_data_in.rejected     = rej_next;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= RESET_WIDTH;
         height_ff      <= RESET_HEIGHT;
         edge_ff        <= RESET_EDGE;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         acc_ff         <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         rej_ff         <= 1'b0;
         thr_ff         <= '0;
         centres_ff     <= '0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         edge_ff        <= edge_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         acc_ff         <= acc_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         rej_ff         <= rej_in;
         thr_ff         <= thr_in;
         centres_ff     <= centres_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      stage_data_ff <= stage_data_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== sv/pssd_checker.sv =====
// Port-level checks for patch_ssd_distance_unit, bound to the top level.
// Depends on pssd_pkg for the payload types.
`default_nettype none

module pssd_checker
   import pssd_pkg::*;
(
   input wire     clock,
   input wire     reset,
   input wire     req_ready,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_data
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a response leaves only when taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("response dropped without being taken");

   // a rejected response carries the all-ones distance
   a_rej_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.distance_sum == SUM_MASK)
      else $error("rejected response without all-ones distance");

   // requests back up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind patch_ssd_distance_unit pssd_checker u_pssd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/patch_ssd_distance_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for patch_ssd_distance_unit: streams patch comparisons, predicts
// each patch distance in a behavioral copy and checks every response.
// Depends on pssd_pkg and the unit's RTL.

module patch_ssd_distance_unit_tb
   import pssd_pkg::*;
();

   // Far above the slowest legal run: about 2200 requests, each waiting out the
   // longest sender gap and the longest response stall, plus the settle pauses.
   localparam int unsigned RUN_LIMIT      = 400_000;
   localparam int unsigned RANDOM_PAIRS   = 200;
   localparam int unsigned QUIET_AFTER    = 140;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned MAX_REPORTS    = 10;

   // How the colors of a patch's later requests are made.
   typedef enum int {
      COLORS_RANDOM,
      COLORS_CLOSE,
      COLORS_FIXED
   } color_mode_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_ready;
   req_type       req_data    = '0;
   logic          rsp_valid;
   logic          rsp_ready   = 1'b0;
   rsp_type       rsp_data;
   logic          csr_wr_en   = 1'b0;
   csr_index_type csr_index   = CSR_IMAGE_WIDTH;
   logic [DIM_REG_W-1:0] csr_wr_data = '0;

   // Register mirror, as the unit holds it after reset.
   logic [DIM_REG_W-1:0] cfg_width  = RESET_WIDTH;
   logic [DIM_REG_W-1:0] cfg_height = RESET_HEIGHT;
   logic [EDGE_W-1:0]    cfg_edge   = RESET_EDGE;

   // Patch state of the behavioral copy; all zero means the next request
   // opens a patch.
   logic [SUM_W-1:0]  acc_sum      = '0;
   logic [OFFS_W-1:0] col_off      = '0;
   logic [OFFS_W-1:0] row_off      = '0;
   bit                reject_seen  = 1'b0;
   logic [SUM_W-1:0]  thr_held     = '0;
   centre_type        centres_held = '0;

   rsp_type     pending_distances[$];
   int unsigned pairs_sent    = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   bit          idling_off    = 1'b0;

   patch_ssd_distance_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Behavioral copy of the unit
   // ---------------------------------------------------------------------

   // Patch size in use: the register clamped to the supported range.
   function automatic int unsigned patch_in_use();
      int unsigned p;
      p = cfg_edge;
      if (p < MIN_EDGE) p = MIN_EDGE;
      if (p > DEFAULT_MAX_PATCH) p = DEFAULT_MAX_PATCH;
      return p;
   endfunction

   // Image dimension in use: larger register values clamp to the maximum.
   function automatic int unsigned dim_in_use(logic [DIM_REG_W-1:0] dim);
      return (dim > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(dim);
   endfunction

   function automatic bit off_image(logic [COORD_W-1:0] centre, int rel, int unsigned lim);
      int pos;
      pos = int'(centre) + rel;
      return (pos < 0) || (pos >= int'(lim));
   endfunction

   function automatic int unsigned sq_diff(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   // Fold one accepted pixel pair into the patch; done marks the patch's
   // last pair, and res then holds the response it must produce.
   task automatic predict_patch_distance(input req_type px, output bit done,
                                         output rsp_type res);
      int unsigned side_half, last_off, w, h, cost, total;
      int dx, dy;
      side_half = patch_in_use() / 2;
      last_off  = 2 * side_half - 1;
      w = dim_in_use(cfg_width);
      h = dim_in_use(cfg_height);

      // First pair of a patch latches threshold and centers, clears the sum.
      if (col_off == 0 && row_off == 0) begin
         thr_held           = px.reject_threshold;
         centres_held.src_x = px.src_center_x;
         centres_held.src_y = px.src_center_y;
         centres_held.tgt_x = px.tgt_center_x;
         centres_held.tgt_y = px.tgt_center_y;
         acc_sum            = '0;
         reject_seen        = 1'b0;
      end

      // Once rejected, the rest of the patch only advances the offsets.
      if (!reject_seen) begin
         dx = int'(col_off) - int'(side_half);
         dy = int'(row_off) - int'(side_half);
         if (off_image(centres_held.src_x, dx, w) || off_image(centres_held.src_y, dy, h) ||
             off_image(centres_held.tgt_x, dx, w) || off_image(centres_held.tgt_y, dy, h)) begin
            reject_seen = 1'b1;
         end else begin
            cost = sq_diff(px.src_red, px.tgt_red) + sq_diff(px.src_green, px.tgt_green) +
                   sq_diff(px.src_blue, px.tgt_blue);
            total = acc_sum + cost;
            if (total > SUM_MASK) total = SUM_MASK;
            acc_sum = SUM_W'(total);
            if (total > thr_held) reject_seen = 1'b1;
         end
      end

      // Offsets at or past the last column wrap, even after a size change.
      done = (col_off >= last_off) && (row_off >= last_off);
      res.distance_sum = reject_seen ? SUM_MASK : acc_sum;
      res.rejected     = reject_seen;
      if (done) begin
         col_off = '0;
         row_off = '0;
      end else if (col_off >= last_off) begin
         col_off = '0;
         row_off = row_off + 1'b1;
      end else begin
         col_off = col_off + 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls and the checker
   // ---------------------------------------------------------------------

   initial begin : rsp_stalls
      forever begin
         @(posedge clock);
         if (!idling_off && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Compare each accepted response with the oldest predicted distance.
   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_distances.size() == 0) begin
            note_mismatch($sformatf("unexpected response sum %h rejected %b",
                                    rsp_data.distance_sum, rsp_data.rejected));
         end else begin
            want = pending_distances.pop_front();
            if (rsp_data.distance_sum !== want.distance_sum ||
                rsp_data.rejected !== want.rejected)
               note_mismatch($sformatf("expected sum %h rejected %b, got sum %h rejected %b",
                                       want.distance_sum, want.rejected,
                                       rsp_data.distance_sum, rsp_data.rejected));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Send one pixel-pair request. Valid stays high after acceptance so that
   // back-to-back requests need no second assignment in the same step; a
   // gap or a settle lowers it.
   task automatic send_pixel_pair(input req_type px, output bit done);
      rsp_type res;
      if (!idling_off && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_patch_distance(px, done, res);
      if (done) pending_distances.push_back(res);
      pairs_sent++;
   endtask

   // Drop valid, drain every expected response, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DIM_REG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value;
         CSR_IMAGE_HEIGHT: cfg_height = value;
         CSR_PATCH_EDGE:   cfg_edge   = value[EDGE_W-1:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_geometry(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h,
                                 input logic [DIM_REG_W-1:0] p);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_PATCH_EDGE, p);
   endtask

   // Random pixel pair; every field random unless the color mode says
   // otherwise. Threshold and center fields only matter on a patch's first.
   function automatic req_type random_pair(color_mode_type mode, req_type head);
      logic [127:0] raw;
      req_type      px;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      px  = raw[$bits(req_type)-1:0];
      case (mode)
         COLORS_CLOSE: begin
            px.tgt_red   = px.src_red   ^ COLOR_W'($urandom_range(0, 15));
            px.tgt_green = px.src_green ^ COLOR_W'($urandom_range(0, 15));
            px.tgt_blue  = px.src_blue  ^ COLOR_W'($urandom_range(0, 15));
         end
         COLORS_FIXED: begin
            px.src_red   = head.src_red;
            px.src_green = head.src_green;
            px.src_blue  = head.src_blue;
            px.tgt_red   = head.tgt_red;
            px.tgt_green = head.tgt_green;
            px.tgt_blue  = head.tgt_blue;
         end
         default: ;
      endcase
      return px;
   endfunction

   // Send head, then further pairs until the patch ends or stop_after pairs
   // have gone (zero: no cap).
   task automatic send_patch(input req_type head, input color_mode_type mode,
                             input int unsigned stop_after = 0);
      bit          done;
      int unsigned count;
      send_pixel_pair(head, done);
      count = 1;
      while (!done && (stop_after == 0 || count < stop_after)) begin
         send_pixel_pair(random_pair(mode, head), done);
         count++;
      end
   endtask

   function automatic req_type centred_head(color_mode_type mode, int unsigned sx,
                                            int unsigned sy, int unsigned tx, int unsigned ty,
                                            logic [SUM_W-1:0] thr);
      req_type head;
      head = random_pair(mode, '0);
      head.src_center_x     = COORD_W'(sx);
      head.src_center_y     = COORD_W'(sy);
      head.tgt_center_x     = COORD_W'(tx);
      head.tgt_center_y     = COORD_W'(ty);
      head.reject_threshold = thr;
      return head;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Widest color differences, thresholds at zero and at all ones.
   task automatic test_color_extremes();
      req_type head;
      settle();
      write_geometry(13'd4096, 13'd4096, 13'd2);
      // Full-scale difference on every channel, never rejected.
      head = centred_head(COLORS_FIXED, 1, 1, 4095, 4095, SUM_MASK);
      {head.src_red, head.src_green, head.src_blue} = '1;
      {head.tgt_red, head.tgt_green, head.tgt_blue} = '0;
      send_patch(head, COLORS_FIXED);
      // Zero threshold, opposite extremes: rejected on the first pair.
      head = centred_head(COLORS_FIXED, 4095, 4095, 1, 1, '0);
      {head.src_red, head.src_green, head.src_blue} = '0;
      {head.tgt_red, head.tgt_green, head.tgt_blue} = '1;
      send_patch(head, COLORS_FIXED);
      // Sum equal to a zero threshold still passes.
      head = centred_head(COLORS_FIXED, 2048, 2048, 2048, 2048, '0);
      {head.tgt_red, head.tgt_green, head.tgt_blue} =
         {head.src_red, head.src_green, head.src_blue};
      send_patch(head, COLORS_FIXED);
   endtask

   // Coordinates past the left, top and bottom borders; zero and clamped sizes.
   task automatic test_image_bounds();
      settle();
      write_geometry(13'd4096, 13'd4096, 13'd2);
      send_patch(centred_head(COLORS_CLOSE, 0, 10, 10, 10, SUM_MASK), COLORS_CLOSE);
      send_patch(centred_head(COLORS_CLOSE, 10, 10, 10, 0, SUM_MASK), COLORS_CLOSE);
      settle();
      write_reg(CSR_IMAGE_HEIGHT, 13'd4095);
      send_patch(centred_head(COLORS_CLOSE, 5, 5, 5, 4095, SUM_MASK), COLORS_CLOSE);
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd0);
      send_patch(centred_head(COLORS_CLOSE, 5, 5, 5, 5, SUM_MASK), COLORS_CLOSE);
      settle();
      // Oversized registers clamp to the largest image.
      write_geometry(13'h1FFF, 13'd4352, 13'd2);
      send_patch(centred_head(COLORS_CLOSE, 4095, 4095, 4095, 4095, SUM_MASK), COLORS_CLOSE);
   endtask

   // Patch sizes below the minimum and an odd size.
   task automatic test_edge_clamp();
      settle();
      write_geometry(13'd4096, 13'd4096, 13'd0);
      send_patch(centred_head(COLORS_RANDOM, 100, 200, 300, 400, SUM_MASK), COLORS_RANDOM);
      settle();
      write_reg(CSR_PATCH_EDGE, 13'd1);
      send_patch(centred_head(COLORS_RANDOM, 100, 200, 300, 400, SUM_MASK), COLORS_RANDOM);
      settle();
      write_reg(CSR_PATCH_EDGE, 13'd3);
      send_patch(centred_head(COLORS_RANDOM, 100, 200, 300, 400, SUM_MASK), COLORS_RANDOM);
   endtask

   // Change the patch size while a patch is open, with the unit idle: offsets
   // past the new last column wrap, past both corners end the patch.
   task automatic test_edge_change_midpatch();
      settle();
      write_geometry(13'd1024, 13'd1024, 13'd4);
      send_patch(centred_head(COLORS_CLOSE, 100, 100, 200, 200, SUM_MASK), COLORS_CLOSE, 5);
      settle();
      write_reg(CSR_PATCH_EDGE, 13'd2);
      send_patch(random_pair(COLORS_CLOSE, '0), COLORS_CLOSE);

      settle();
      write_reg(CSR_PATCH_EDGE, 13'd6);
      send_patch(centred_head(COLORS_CLOSE, 300, 300, 50, 50, SUM_MASK), COLORS_CLOSE, 5);
      settle();
      write_reg(CSR_PATCH_EDGE, 13'd2);
      send_patch(random_pair(COLORS_CLOSE, '0), COLORS_CLOSE);

      settle();
      send_patch(centred_head(COLORS_CLOSE, 500, 500, 600, 600, SUM_MASK), COLORS_CLOSE, 2);
      settle();
      write_reg(CSR_PATCH_EDGE, 13'd8);
      send_patch(random_pair(COLORS_CLOSE, '0), COLORS_CLOSE);
   endtask

   // One random patch: mostly centers well inside the image with thresholds
   // near the likely sum, the rest fully random fields.
   task automatic random_patch();
      req_type        head;
      color_mode_type mode;
      int unsigned    side_half, w, h, n;
      side_half = patch_in_use() / 2;
      w = dim_in_use(cfg_width);
      h = dim_in_use(cfg_height);
      n = 4 * side_half * side_half;
      mode = ($urandom_range(0, 1) == 0) ? COLORS_CLOSE : COLORS_RANDOM;
      head = random_pair(mode, '0);
      if ($urandom_range(0, 9) < 7 && w >= 2 * side_half && h >= 2 * side_half) begin
         head.src_center_x = COORD_W'($urandom_range(side_half, w - side_half));
         head.src_center_y = COORD_W'($urandom_range(side_half, h - side_half));
         head.tgt_center_x = COORD_W'($urandom_range(side_half, w - side_half));
         head.tgt_center_y = COORD_W'($urandom_range(side_half, h - side_half));
         case ($urandom_range(0, 2))
            0:       head.reject_threshold = SUM_MASK;
            1:       head.reject_threshold = SUM_W'($urandom_range(0, n * 400));
            default: head.reject_threshold = SUM_W'($urandom_range(0, n * 40000));
         endcase
      end
      send_patch(head, mode);
   endtask

   function automatic logic [DIM_REG_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return DIM_REG_W'($urandom_range(4097, 8191));
         2:       return '1;
         3:       return DIM_REG_W'($urandom_range(1, 16));
         4:       return DIM_REG_W'(4096);
         default: return DIM_REG_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // Random geometry per phase, a few patches each; the tail runs with no
   // gaps and no stalls.
   task automatic test_random_streams();
      int unsigned start, p;
      start = pairs_sent;
      while (pairs_sent - start < RANDOM_PAIRS) begin
         settle();
         if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1);
         else if ($urandom_range(0, 3) == 0) p = $urandom_range(7, 12);
         else p = $urandom_range(2, 6);
         // Upper data bits are junk for the 6-bit size register.
         write_geometry(random_dim(), random_dim(),
                        {DIM_REG_W'($urandom_range(0, 127)) << EDGE_W} | DIM_REG_W'(p));
         if (pairs_sent - start > QUIET_AFTER) idling_off = 1'b1;
         repeat ($urandom_range(2, 6)) random_patch();
      end
   endtask

   // Largest patch: a size register of all ones clamps to the maximum.
   task automatic test_largest_patch();
      settle();
      write_geometry(13'd4096, 13'd4096, 13'd63);
      send_patch(centred_head(COLORS_RANDOM, 2048, 16, 4079, 4080, SUM_MASK), COLORS_RANDOM);
   endtask

   initial begin : test_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_color_extremes();
      test_image_bounds();
      test_edge_clamp();
      test_edge_change_midpatch();
      test_largest_patch();
      test_random_streams();
      settle();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/pssd_pkg.sv
sv/pssd_pixel_cost.sv
sv/pssd_bounds.sv
sv/patch_ssd_distance_unit.sv
sv/pssd_checker.sv
tb/sv/patch_ssd_distance_unit_tb.sv
